@@ sv/assert_macros.svh @@
// ---------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion wrappers, compiled out with ASSERT_OFF
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`define ASSERT_NEVER(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) !(expr)) \
      else $error("assertion failed");
`else
`define ASSERT_IMPLY(label, clk, rst, ante, cons)
`define ASSERT_NEVER(label, clk, rst, expr)
`endif
`endif

@@ sv/pda_pkg.sv @@
// ---------------------------------------------------------------------------
// pda_pkg
// types and constants of the pixel disturbance alert update pipeline
// ---------------------------------------------------------------------------
package pda_pkg;

   localparam int ANOM_W     = 16;
   localparam int LVL_W      = 15;
   localparam int DAY_W      = 16;
   localparam int CONF_W     = 16;
   localparam int STAT_W     = 3;
   localparam int HITS_W     = 8;
   localparam int PCT_W      = 7;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;

   // derived arithmetic widths
   localparam int PN_W   = 15;  // miss count and percent divide operands
   localparam int SQ_W   = 16;  // square of a hit count
   localparam int PROD_W = 31;  // 16 x 15 products
   localparam int X_W    = 32;
   localparam int NUM_W  = 48;
   localparam int DSAT_W = 47;

   // divider shapes
   localparam int PN_QUO_W    = 15;
   localparam int PCT_QUO_W   = 8;
   localparam int CONF_QUO_W  = 16;
   localparam int PN_STEP_N   = 5;
   localparam int PCT_STEP_N  = 4;
   localparam int CONF_STEP_N = 2;

   // status codes
   localparam logic [STAT_W-1:0] ST_NONE        = 3'd0;
   localparam logic [STAT_W-1:0] ST_PROV_WEAK   = 3'd1;
   localparam logic [STAT_W-1:0] ST_CONF_WEAK   = 3'd2;
   localparam logic [STAT_W-1:0] ST_PROV_STRONG = 3'd3;
   localparam logic [STAT_W-1:0] ST_CONF_STRONG = 3'd4;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_CURRENT_DAY   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ANOMALY_LEVEL = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_STRONG_LEVEL  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_CONFIRM_LEVEL = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_WINDOW_DAYS   = 3'd4;

   // register reset values
   localparam logic [DAY_W-1:0]  RST_CURRENT_DAY   = 16'd0;
   localparam logic [LVL_W-1:0]  RST_ANOMALY_LEVEL = 15'd50;
   localparam logic [LVL_W-1:0]  RST_STRONG_LEVEL  = 15'd200;
   localparam logic [CONF_W-1:0] RST_CONFIRM_LEVEL = 16'd1600;
   localparam logic [DAY_W-1:0]  RST_WINDOW_DAYS   = 16'd365;

   localparam logic [HITS_W-1:0] HITS_CAP     = 8'd253;
   localparam logic [PCT_W-1:0]  PCT_FULL     = 7'd100;
   localparam logic [PCT_W-1:0]  PCT_LOW      = 7'd33;
   localparam logic [CONF_W-1:0] CONF_SAT     = 16'd65000;
   localparam logic [16:0]       CONF_SAT_P1  = 17'd65001;

   typedef struct packed {
      logic [STAT_W-1:0] status;
      logic [LVL_W-1:0]  peak;
      logic [CONF_W-1:0] conf;
      logic [DAY_W-1:0]  start;
      logic [HITS_W-1:0] hits;
      logic [PCT_W-1:0]  pct;
      logic [DAY_W-1:0]  dur;
      logic [DAY_W-1:0]  last;
   } rec_type;

   // everything that travels down the pipeline with one request
   typedef struct packed {
      logic              obs;
      logic              disturbed;
      logic [LVL_W-1:0]  a;
      rec_type           raw;
      rec_type           cur;
      logic [HITS_W-1:0] pc;
      logic [PN_W-1:0]   pnum;
      logic [PN_W-1:0]   pn;
      logic [SQ_W-1:0]   pc2;
      logic              need_div;
      logic [PN_W-1:0]   dnum;
      logic [PN_W-1:0]   dden;
      logic [PROD_W-1:0] t1;
      logic [PROD_W-1:0] t2;
      logic [PN_W-1:0]   pcpn1;
      logic [X_W-1:0]    x;
      logic [PROD_W-1:0] den;
      logic [SQ_W-1:0]   h2;
      logic [NUM_W-1:0]  num;
      logic [DSAT_W-1:0] dsat;
      logic              sat;
   } ctx_type;

endpackage

@@ sv/pda_div.sv @@
// ---------------------------------------------------------------------------
// pda_div
// pipelined restoring divider, a few quotient bits per stage, with side data
// ---------------------------------------------------------------------------
module pda_div #(
   parameter int NUM_W  = pda_pkg::PN_W,
   parameter int DEN_W  = pda_pkg::PCT_W,
   parameter int QUO_W  = pda_pkg::PN_QUO_W,
   parameter int STEP_N = pda_pkg::PN_STEP_N,
   parameter int SIDE_W = 1
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   input  logic [NUM_W-1:0]  num,
   input  logic [DEN_W-1:0]  den,
   input  logic [SIDE_W-1:0] side_in,
   output logic              out_valid,
   output logic [QUO_W-1:0]  quo,
   output logic [SIDE_W-1:0] side_out
);

   localparam int STAGE_N = (QUO_W + STEP_N - 1) / STEP_N;
   localparam int XW      = (NUM_W > DEN_W + QUO_W) ? NUM_W : DEN_W + QUO_W;

   logic              vld_ff  [STAGE_N];
   logic [NUM_W-1:0]  rem_ff  [STAGE_N];
   logic [QUO_W-1:0]  quo_ff  [STAGE_N];
   logic [DEN_W-1:0]  den_ff  [STAGE_N];
   logic [SIDE_W-1:0] side_ff [STAGE_N];

   logic              vld_src  [STAGE_N];
   logic [NUM_W-1:0]  rem_src  [STAGE_N];
   logic [QUO_W-1:0]  quo_src  [STAGE_N];
   logic [DEN_W-1:0]  den_src  [STAGE_N];
   logic [SIDE_W-1:0] side_src [STAGE_N];

   logic [NUM_W-1:0]  rem_in [STAGE_N];
   logic [QUO_W-1:0]  quo_in [STAGE_N];

   genvar s;
   for (s = 0; s < STAGE_N; s++) begin : g_stage
      if (s == 0) begin : g_first
         assign vld_src[s]  = in_valid;
         assign rem_src[s]  = num;
         assign quo_src[s]  = '0;
         assign den_src[s]  = den;
         assign side_src[s] = side_in;
      end else begin : g_next
         assign vld_src[s]  = vld_ff[s-1];
         assign rem_src[s]  = rem_ff[s-1];
         assign quo_src[s]  = quo_ff[s-1];
         assign den_src[s]  = den_ff[s-1];
         assign side_src[s] = side_ff[s-1];
      end

      always_comb begin : p_steps
         logic [NUM_W-1:0] rem_v;
         logic [QUO_W-1:0] quo_v;
         logic [XW-1:0]    sh_v;
         int               bi;
         rem_v = rem_src[s];
         quo_v = quo_src[s];
         sh_v  = '0;
         bi    = 0;
         for (int k = 0; k < STEP_N; k++) begin
            if (s * STEP_N + k < QUO_W) begin
               bi   = QUO_W - 1 - (s * STEP_N + k);
               sh_v = XW'(den_src[s]) << bi;
               if (XW'(rem_v) >= sh_v) begin
                  rem_v = rem_v - sh_v[NUM_W-1:0];
                  quo_v = quo_v | (QUO_W'(1) << bi);
               end
            end
         end
         rem_in[s] = rem_v;
         quo_in[s] = quo_v;
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[s] <= 1'b0;
         end else begin
            vld_ff[s] <= vld_src[s];
         end
         rem_ff[s]  <= rem_in[s];
         quo_ff[s]  <= quo_in[s];
         den_ff[s]  <= den_src[s];
         side_ff[s] <= side_src[s];
      end
   end

   assign out_valid = vld_ff[STAGE_N-1];
   assign quo       = quo_ff[STAGE_N-1];
   assign side_out  = side_ff[STAGE_N-1];

endmodule

@@ sv/pixel_disturbance_alert_update.sv @@
// ---------------------------------------------------------------------------
// pixel_disturbance_alert_update
// per-pixel disturbance alert record update, fully pipelined
// ---------------------------------------------------------------------------
// One request (a pixel's anomaly and its stored alert record) is taken in
// every clock cycle while start is high; busy is always low, so a raster can
// be streamed with no gaps. The updated record comes out on the rsp_ ports
// for exactly one cycle with rsp_valid high; there is no back pressure, so
// the receiver must take it then. A request passes through s1, s2, three
// pipelined restoring dividers in series (miss count, percent, confidence)
// with s3 between the first two and s4 to s6 between the last two, and the
// output register. The csr_ registers are read live by s1, s3 and the final
// stage: write them only while no request is in flight.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module pixel_disturbance_alert_update #(
   parameter int PN_STEP_N   = pda_pkg::PN_STEP_N,
   parameter int PCT_STEP_N  = pda_pkg::PCT_STEP_N,
   parameter int CONF_STEP_N = pda_pkg::CONF_STEP_N
) (
   input  logic                              clock,
   input  logic                              reset,
   // request channel
   input  logic                              start,
   output logic                              busy,
   input  logic signed [pda_pkg::ANOM_W-1:0] req_anomaly,
   input  logic [pda_pkg::STAT_W-1:0]        req_old_status,
   input  logic [pda_pkg::LVL_W-1:0]         req_old_peak,
   input  logic [pda_pkg::CONF_W-1:0]        req_old_confidence,
   input  logic [pda_pkg::DAY_W-1:0]         req_old_start_day,
   input  logic [pda_pkg::HITS_W-1:0]        req_old_hits,
   input  logic [pda_pkg::PCT_W-1:0]         req_old_percent,
   input  logic [pda_pkg::DAY_W-1:0]         req_old_duration,
   input  logic [pda_pkg::DAY_W-1:0]         req_old_last_seen,
   // result channel
   output logic                              rsp_valid,
   output logic [pda_pkg::STAT_W-1:0]        rsp_new_status,
   output logic [pda_pkg::LVL_W-1:0]         rsp_new_peak,
   output logic [pda_pkg::CONF_W-1:0]        rsp_new_confidence,
   output logic [pda_pkg::DAY_W-1:0]         rsp_new_start_day,
   output logic [pda_pkg::HITS_W-1:0]        rsp_new_hits,
   output logic [pda_pkg::PCT_W-1:0]         rsp_new_percent,
   output logic [pda_pkg::DAY_W-1:0]         rsp_new_duration,
   output logic [pda_pkg::DAY_W-1:0]         rsp_new_last_seen,
   // configuration
   input  logic                              csr_we,
   input  logic [pda_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [pda_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   import pda_pkg::*;

   localparam int SIDE_W  = $bits(ctx_type);
   localparam int PN_SN   = (PN_QUO_W + PN_STEP_N - 1) / PN_STEP_N;
   localparam int PCT_SN  = (PCT_QUO_W + PCT_STEP_N - 1) / PCT_STEP_N;
   localparam int CONF_SN = (CONF_QUO_W + CONF_STEP_N - 1) / CONF_STEP_N;
   // s1, s2, s3, s4, s5, s6 and the output register, plus the dividers
   localparam int LAT_N   = 7 + PN_SN + PCT_SN + CONF_SN;

   // ---------------------------------------------------------------------
   // configuration registers
   // ---------------------------------------------------------------------
   logic [DAY_W-1:0]  cfg_day_ff;
   logic [LVL_W-1:0]  cfg_anom_ff;
   logic [LVL_W-1:0]  cfg_strong_ff;
   logic [CONF_W-1:0] cfg_confirm_ff;
   logic [DAY_W-1:0]  cfg_window_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_day_ff     <= RST_CURRENT_DAY;
         cfg_anom_ff    <= RST_ANOMALY_LEVEL;
         cfg_strong_ff  <= RST_STRONG_LEVEL;
         cfg_confirm_ff <= RST_CONFIRM_LEVEL;
         cfg_window_ff  <= RST_WINDOW_DAYS;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_CURRENT_DAY:   cfg_day_ff     <= csr_wdata;
            CSR_ANOMALY_LEVEL: cfg_anom_ff    <= csr_wdata[LVL_W-1:0];
            CSR_STRONG_LEVEL:  cfg_strong_ff  <= csr_wdata[LVL_W-1:0];
            CSR_CONFIRM_LEVEL: cfg_confirm_ff <= csr_wdata;
            CSR_WINDOW_DAYS:   cfg_window_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   // no back pressure anywhere: a request enters every cycle
   assign busy = 1'b0;

   // ---------------------------------------------------------------------
   // s1: observation check, percent clamp, window clear
   // ---------------------------------------------------------------------
   ctx_type s1_in, s1_ff;
   logic    s1_vld_ff;

   always_comb begin : p_s1
      logic signed [DAY_W+1:0] age_v;
      rec_type                 rec_v;
      rec_v.status = req_old_status;
      rec_v.peak   = req_old_peak;
      rec_v.conf   = req_old_confidence;
      rec_v.start  = req_old_start_day;
      rec_v.hits   = req_old_hits;
      rec_v.pct    = req_old_percent;
      rec_v.dur    = req_old_duration;
      rec_v.last   = req_old_last_seen;

      s1_in           = '0;
      s1_in.raw       = rec_v;
      s1_in.obs       = ~req_anomaly[ANOM_W-1];
      s1_in.a         = req_anomaly[LVL_W-1:0];
      s1_in.disturbed = (req_anomaly[LVL_W-1:0] >= cfg_anom_ff);

      rec_v.last = cfg_day_ff;
      if (rec_v.pct > PCT_FULL) begin
         rec_v.pct = PCT_FULL;
      end
      // start day after current day gives a negative age: no clear
      age_v = $signed({2'b00, cfg_day_ff}) - $signed({2'b00, req_old_start_day});
      if (age_v > $signed({2'b00, cfg_window_ff})) begin
         rec_v.status = ST_NONE;
         rec_v.pct    = '0;
         rec_v.hits   = '0;
         rec_v.peak   = '0;
         rec_v.conf   = '0;
         rec_v.start  = '0;
         rec_v.dur    = '0;
      end
      s1_in.cur = rec_v;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
      end else begin
         s1_vld_ff <= start & ~busy;
      end
      s1_ff <= s1_in;
   end

   // ---------------------------------------------------------------------
   // s2: miss count numerator and old hit count squared
   // ---------------------------------------------------------------------
   ctx_type s2_in, s2_ff;
   logic    s2_vld_ff;

   always_comb begin : p_s2
      logic [PCT_W-1:0] miss_pct_v;
      s2_in      = s1_ff;
      miss_pct_v = PCT_FULL - s1_ff.cur.pct;
      s2_in.pc   = s1_ff.cur.hits;
      s2_in.pnum = PN_W'(miss_pct_v) * PN_W'(s1_ff.cur.hits);
      s2_in.pc2  = SQ_W'(s1_ff.cur.hits) * SQ_W'(s1_ff.cur.hits);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_vld_ff <= 1'b0;
      end else begin
         s2_vld_ff <= s1_vld_ff;
      end
      s2_ff <= s2_in;
   end

   // ---------------------------------------------------------------------
   // miss count divide: (100 - percent) * hits / percent
   // ---------------------------------------------------------------------
   logic                vld_a;
   logic [PN_QUO_W-1:0] quo_a;
   logic [SIDE_W-1:0]   side_a;

   pda_div #(
      .NUM_W  (PN_W),
      .DEN_W  (PCT_W),
      .QUO_W  (PN_QUO_W),
      .STEP_N (PN_STEP_N),
      .SIDE_W (SIDE_W)
   ) u_div_pn (
      .clock    (clock),
      .reset    (reset),
      .in_valid (s2_vld_ff),
      .num      (s2_ff.pnum),
      .den      (s2_ff.cur.pct),
      .side_in  (s2_ff),
      .out_valid(vld_a),
      .quo      (quo_a),
      .side_out (side_a)
   );

   // ---------------------------------------------------------------------
   // s3: alert start or extend, percent divide operands, confidence terms
   // ---------------------------------------------------------------------
   ctx_type s3_in, s3_ff;
   logic    s3_vld_ff;

   always_comb begin : p_s3
      ctx_type         c_v;
      logic [PN_W-1:0] pcpn_v;
      c_v = ctx_type'(side_a);
      // zero percent gives no misses
      c_v.pn   = (c_v.cur.pct == '0) ? '0 : quo_a;
      pcpn_v   = PN_W'(c_v.pc) + c_v.pn;
      c_v.pcpn1    = pcpn_v + PN_W'(1);
      c_v.need_div = 1'b0;
      if (c_v.disturbed) begin
         if (c_v.cur.start == '0) begin
            c_v.cur.start = cfg_day_ff;
            c_v.cur.peak  = c_v.a;
            c_v.cur.pct   = PCT_FULL;
            c_v.cur.hits  = HITS_W'(1);
         end else begin
            if (c_v.a > c_v.cur.peak) begin
               c_v.cur.peak = c_v.a;
            end
            if (c_v.cur.hits < HITS_CAP) begin
               c_v.cur.hits = c_v.cur.hits + HITS_W'(1);
               c_v.need_div = 1'b1;
            end
         end
         c_v.cur.dur = cfg_day_ff - c_v.cur.start + DAY_W'(1);
      end else if (c_v.cur.pct != '0) begin
         c_v.need_div = 1'b1;
      end
      c_v.dnum = PN_W'(c_v.cur.hits) * PN_W'(PCT_FULL);
      c_v.dden = c_v.disturbed ? (PN_W'(c_v.cur.hits) + c_v.pn) : c_v.pcpn1;
      c_v.t1   = PROD_W'(c_v.cur.conf) * PROD_W'(pcpn_v);
      c_v.t2   = PROD_W'(c_v.a) * PROD_W'(c_v.pc2);
      s3_in    = c_v;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_vld_ff <= 1'b0;
      end else begin
         s3_vld_ff <= vld_a;
      end
      s3_ff <= s3_in;
   end

   // ---------------------------------------------------------------------
   // percent divide
   // ---------------------------------------------------------------------
   logic                 vld_b;
   logic [PCT_QUO_W-1:0] quo_b;
   logic [SIDE_W-1:0]    side_b;

   pda_div #(
      .NUM_W  (PN_W),
      .DEN_W  (PN_W),
      .QUO_W  (PCT_QUO_W),
      .STEP_N (PCT_STEP_N),
      .SIDE_W (SIDE_W)
   ) u_div_pct (
      .clock    (clock),
      .reset    (reset),
      .in_valid (s3_vld_ff),
      .num      (s3_ff.dnum),
      .den      (s3_ff.dden),
      .side_in  (s3_ff),
      .out_valid(vld_b),
      .quo      (quo_b),
      .side_out (side_b)
   );

   // ---------------------------------------------------------------------
   // s4: new percent, confidence sum, denominator, new hits squared
   // ---------------------------------------------------------------------
   ctx_type s4_in, s4_ff;
   logic    s4_vld_ff;

   always_comb begin : p_s4
      ctx_type c_v;
      c_v = ctx_type'(side_b);
      if (c_v.need_div) begin
         c_v.cur.pct = quo_b[PCT_W-1:0];
      end
      c_v.x   = X_W'(c_v.t1) + X_W'(c_v.t2);
      c_v.den = PROD_W'(c_v.pc2) * PROD_W'(c_v.pcpn1);
      c_v.h2  = SQ_W'(c_v.cur.hits) * SQ_W'(c_v.cur.hits);
      s4_in   = c_v;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_vld_ff <= 1'b0;
      end else begin
         s4_vld_ff <= vld_b;
      end
      s4_ff <= s4_in;
   end

   // ---------------------------------------------------------------------
   // s5: confidence numerator and saturation bound
   // ---------------------------------------------------------------------
   ctx_type s5_in, s5_ff;
   logic    s5_vld_ff;

   always_comb begin : p_s5
      s5_in      = s4_ff;
      s5_in.num  = NUM_W'(s4_ff.x) * NUM_W'(s4_ff.h2);
      s5_in.dsat = DSAT_W'(s4_ff.den) * DSAT_W'(CONF_SAT_P1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s5_vld_ff <= 1'b0;
      end else begin
         s5_vld_ff <= s4_vld_ff;
      end
      s5_ff <= s5_in;
   end

   // ---------------------------------------------------------------------
   // s6: quotient above 65000 saturates
   // ---------------------------------------------------------------------
   ctx_type s6_in, s6_ff;
   logic    s6_vld_ff;

   always_comb begin : p_s6
      s6_in     = s5_ff;
      s6_in.sat = (s5_ff.num >= NUM_W'(s5_ff.dsat));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s6_vld_ff <= 1'b0;
      end else begin
         s6_vld_ff <= s5_vld_ff;
      end
      s6_ff <= s6_in;
   end

   // ---------------------------------------------------------------------
   // confidence divide, only meaningful when not saturated
   // ---------------------------------------------------------------------
   logic                  vld_c;
   logic [CONF_QUO_W-1:0] quo_c;
   logic [SIDE_W-1:0]     side_c;

   pda_div #(
      .NUM_W  (NUM_W),
      .DEN_W  (PROD_W),
      .QUO_W  (CONF_QUO_W),
      .STEP_N (CONF_STEP_N),
      .SIDE_W (SIDE_W)
   ) u_div_conf (
      .clock    (clock),
      .reset    (reset),
      .in_valid (s6_vld_ff),
      .num      (s6_ff.num),
      .den      (s6_ff.den),
      .side_in  (s6_ff),
      .out_valid(vld_c),
      .quo      (quo_c),
      .side_out (side_c)
   );

   // ---------------------------------------------------------------------
   // final: confidence pick, status grading, low-percent provisional clear
   // ---------------------------------------------------------------------
   ctx_type fin_v;
   rec_type out_in;

   always_comb begin : p_fin
      rec_type r_v;
      fin_v = ctx_type'(side_c);
      r_v   = fin_v.cur;
      // confidence with no old hits or no old confidence restarts from the anomaly, or zero if undisturbed
      if (r_v.conf != '0 && fin_v.pc != '0) begin
         r_v.conf = fin_v.sat ? CONF_SAT : quo_c;
      end else begin
         r_v.conf = fin_v.disturbed ? CONF_W'(fin_v.a) : '0;
      end

      if (r_v.peak >= cfg_strong_ff) begin
         if (r_v.conf >= cfg_confirm_ff) begin
            r_v.status = ST_CONF_STRONG;
         end else if (r_v.status != ST_CONF_STRONG) begin
            r_v.status = ST_PROV_STRONG;
         end
      end else if (r_v.peak >= cfg_anom_ff) begin
         if (r_v.conf >= cfg_confirm_ff) begin
            r_v.status = ST_CONF_WEAK;
         end else if (r_v.status != ST_CONF_WEAK) begin
            r_v.status = ST_PROV_WEAK;
         end
      end else begin
         r_v.status = ST_NONE;
      end

      if (r_v.pct <= PCT_LOW &&
          (r_v.status == ST_PROV_WEAK || r_v.status == ST_PROV_STRONG)) begin
         r_v.status = ST_NONE;
         r_v.pct    = '0;
         r_v.hits   = '0;
         r_v.peak   = '0;
         r_v.conf   = '0;
         r_v.start  = '0;
         r_v.dur    = '0;
      end

      // no observation: record passes through untouched
      out_in = fin_v.obs ? r_v : fin_v.raw;
   end

   // ---------------------------------------------------------------------
   // output register
   // ---------------------------------------------------------------------
   logic    rsp_valid_ff;
   logic    rsp_obs_ff;
   rec_type rsp_rec_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= vld_c;
      end
      rsp_obs_ff <= fin_v.obs;
      rsp_rec_ff <= out_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_new_status     = rsp_rec_ff.status;
   assign rsp_new_peak       = rsp_rec_ff.peak;
   assign rsp_new_confidence = rsp_rec_ff.conf;
   assign rsp_new_start_day  = rsp_rec_ff.start;
   assign rsp_new_hits       = rsp_rec_ff.hits;
   assign rsp_new_percent    = rsp_rec_ff.pct;
   assign rsp_new_duration   = rsp_rec_ff.dur;
   assign rsp_new_last_seen  = rsp_rec_ff.last;

   // ---------------------------------------------------------------------
   // assertions
   // ---------------------------------------------------------------------
   // every result traces back to a request taken on start
   `ASSERT_IMPLY(a_latency, clock, reset, rsp_valid_ff, $past(start, LAT_N))
   // an observed pixel always yields an in-range record
   `ASSERT_IMPLY(a_range, clock, reset, rsp_valid_ff && rsp_obs_ff,
      rsp_rec_ff.conf <= CONF_SAT && rsp_rec_ff.pct <= PCT_FULL &&
      rsp_rec_ff.status <= ST_CONF_STRONG)
   // an observed pixel is stamped with the current day
   `ASSERT_IMPLY(a_last_seen, clock, reset, rsp_valid_ff && rsp_obs_ff,
      rsp_rec_ff.last == cfg_day_ff)
   // low-percent provisional alerts never survive
   `ASSERT_NEVER(a_low_prov, clock, reset, rsp_valid_ff && rsp_obs_ff &&
      rsp_rec_ff.pct <= PCT_LOW &&
      (rsp_rec_ff.status == ST_PROV_WEAK || rsp_rec_ff.status == ST_PROV_STRONG))

endmodule
